// File: rtl/met_pkg.sv
`default_nettype none
package met_pkg;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;
    localparam logic signed [63:0] MAX64 = 64'sh7fffffffffffffff;
    localparam logic signed [63:0] MIN64 = 64'sh8000000000000000;
    localparam int RECIP_W = 24;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage
`default_nettype wire

// File: rtl/met_ram.sv
`default_nettype none
module met_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/met_div.sv
`default_nettype none
// restoring divider: 64-bit magnitude by (k+1)<<16, one quotient bit a cycle
module met_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] acc,
    input  wire logic [8:0]         div_k,
    output logic                    done,
    output logic signed [31:0]      quot,
    output logic                    sat
);
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        neg_reg, neg_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] q_reg, q_next;
    logic [25:0] rem_reg, rem_next;
    logic [24:0] d_reg, d_next;
    logic [63:0] mag;
    logic [26:0] trial;
    logic [64:0] qsum;

    always_comb
    begin
        mag = acc[63] ? (64'd0 - 64'(acc)) : 64'(acc);
        // add half the divisor before dividing
        qsum = {1'b0, mag} + {41'd0, div_k, 15'd0};
        cnt_next = cnt_reg;
        run_next = run_reg;
        neg_next = neg_reg;
        num_next = num_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        trial = 27'd0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 7'd0;
            neg_next = acc[63];
            d_next = {div_k, 16'd0};
            num_next = qsum[63:0];
            q_next = 64'd0;
            rem_next = 26'd0;
        end
        else if (run_reg)
        begin
            trial = {rem_reg, num_reg[63]};
            num_next = {num_reg[62:0], 1'b0};
            if (trial >= {2'd0, d_reg})
            begin
                rem_next = 26'(trial - {2'd0, d_reg});
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[25:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next = 1'b0;
            end
        end
    end

    logic fin_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 7'd0;
            fin_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            fin_reg <= run_reg && !start && cnt_reg == 7'd63;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        sat = 1'b0;
        if (!neg_reg)
        begin
            if (q_reg > 64'h7fffffff)
            begin
                sat = 1'b1;
                quot = met_pkg::MAX32;
            end
            else
            begin
                quot = q_reg[31:0];
            end
        end
        else if (q_reg > 64'h80000000)
        begin
            sat = 1'b1;
            quot = met_pkg::MIN32;
        end
        else
        begin
            quot = 32'(64'd0 - q_reg);
        end
    end
    assign done = fin_reg;
endmodule
`default_nettype wire

// File: rtl/matrix_exponential_taylor.sv
`default_nettype none
// channel  | direction | handshake           | payload
// in       | into      | in_valid/in_stall   | elem_value
// out      | out of    | out_valid/out_stall | result_value, is_last, saturated
// cfg      | into      | cfg_we              | cfg_data (num_terms)
// one matrix of DIM*DIM words is loaded, one word a cycle, then the sum matrix is set to the identity
// each round: the term is added into the sum (SUMR, SUMW), each product element is accumulated
// (MULR, MULA), divided (DIV, WAIT) and copied back (COPY, COPW); num_terms rounds a matrix
// results then leave word by word (OUTR, OUT), the output stall holding each word
// input is stalled from the last element until the final result word is registered
// rst_n returns the controller to loading and num_terms to 100
module matrix_exponential_taylor #(
    parameter int DIM = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] elem_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      result_value,
    output logic                    is_last,
    output logic                    saturated,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_data
);
    localparam int CELLS = DIM * DIM;
    localparam int AW = $clog2(CELLS);
    localparam int DW = $clog2(DIM);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_SUMR = 4'd2;
    localparam logic [3:0] S_SUMW = 4'd3;
    localparam logic [3:0] S_MULR = 4'd4;
    localparam logic [3:0] S_MULA = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_WAIT = 4'd7;
    localparam logic [3:0] S_COPY = 4'd8;
    localparam logic [3:0] S_COPW = 4'd9;
    localparam logic [3:0] S_OUTR = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]  st_reg, st_next;
    logic [7:0]  nt_reg;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [7:0]  k_reg, k_next;
    logic        ovf_reg, ovf_next;
    logic        stuck_reg, stuck_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] res_reg, res_next;
    logic        last_reg, last_next;
    logic        ov_out_reg, ov_out_next;

    logic          a_we, s_we, q_we, p_we;
    logic [AW-1:0] a_wa, s_wa, q_wa, p_wa, a_ra, s_ra, q_ra, p_ra;
    logic [31:0]   a_wd, s_wd, q_wd, p_wd, a_rd, s_rd, q_rd, p_rd;

    met_ram #(.WIDTH(32), .DEPTH(CELLS)) u_a (.clk, .we(a_we), .waddr(a_wa),
        .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
    met_ram #(.WIDTH(32), .DEPTH(CELLS)) u_s (.clk, .we(s_we), .waddr(s_wa),
        .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    met_ram #(.WIDTH(32), .DEPTH(CELLS)) u_q (.clk, .we(q_we), .waddr(q_wa),
        .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
    met_ram #(.WIDTH(32), .DEPTH(CELLS)) u_p (.clk, .we(p_we), .waddr(p_wa),
        .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    logic div_start;
    logic signed [31:0] dq;
    logic dsat, ddone;
    met_div u_div (.clk, .rst_n, .start(div_start), .acc(acc_reg),
        .div_k({1'b0, k_reg} + 9'd1), .done(ddone), .quot(dq), .sat(dsat));

    logic signed [63:0] prod_reg;
    logic signed [32:0] ssum;
    logic signed [64:0] asum;

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(q_rd) * $signed(a_rd);
    end

    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall = (st_reg != S_LOAD);

    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        m_next = m_reg;
        k_next = k_reg;
        ovf_next = ovf_reg;
        stuck_next = stuck_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        last_next = last_reg;
        ov_out_next = ov_out_reg;
        a_we = 1'b0; s_we = 1'b0; q_we = 1'b0; p_we = 1'b0;
        a_wa = cnt_reg; s_wa = cnt_reg; q_wa = cnt_reg; p_wa = AW'(i_reg * DIM + j_reg);
        a_wd = elem_value; s_wd = 32'd0; q_wd = elem_value; p_wd = dq;
        a_ra = AW'(m_reg * DIM + j_reg);
        q_ra = AW'(i_reg * DIM + m_reg);
        s_ra = cnt_reg;
        p_ra = cnt_reg;
        div_start = 1'b0;
        ssum = $signed({s_rd[31], s_rd}) + $signed({q_rd[31], q_rd});
        asum = $signed({acc_reg[63], acc_reg}) + $signed({prod_reg[63], prod_reg});
        case (st_reg)
            S_LOAD:
            begin
                if (accept_in)
                begin
                    a_we = 1'b1;
                    q_we = 1'b1;
                    if (cnt_reg == AW'(CELLS - 1))
                    begin
                        cnt_next = '0;
                        i_next = '0;
                        j_next = '0;
                        ovf_next = 1'b0;
                        st_next = S_INIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
            end
            S_INIT:
            begin
                s_we = 1'b1;
                s_wd = (i_reg == j_reg) ? met_pkg::ONE_Q16 : 32'd0;
                k_next = 8'd1;
                if (j_reg == DW'(DIM - 1))
                begin
                    j_next = '0;
                    i_next = i_reg + DW'(1);
                end
                else
                begin
                    j_next = j_reg + DW'(1);
                end
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next = '0;
                    st_next = (nt_reg == 8'd0) ? S_OUTR : S_SUMR;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_SUMR:
            begin
                q_ra = cnt_reg;
                st_next = S_SUMW;
            end
            S_SUMW:
            begin
                q_ra = cnt_reg;
                s_we = 1'b1;
                if (ssum > 33'sh7fffffff)
                begin
                    s_wd = met_pkg::MAX32;
                    ovf_next = 1'b1;
                end
                else if (ssum < -33'sh80000000)
                begin
                    s_wd = met_pkg::MIN32;
                    ovf_next = 1'b1;
                end
                else
                begin
                    s_wd = ssum[31:0];
                end
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next = '0;
                    i_next = '0; j_next = '0; m_next = '0;
                    acc_next = '0;
                    stuck_next = 1'b0;
                    st_next = S_MULR;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                    st_next = S_SUMR;
                end
            end
            S_MULR:
            begin
                st_next = S_MULA;
            end
            S_MULA:
            begin
                // the read issued in MULR is now on the RAM outputs; prod_reg registers its product
                st_next = S_MULR;
            end
            S_DIV:
            begin
                div_start = 1'b1;
                st_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (ddone)
                begin
                    p_we = 1'b1;
                    if (dsat)
                    begin
                        ovf_next = 1'b1;
                    end
                    acc_next = '0;
                    stuck_next = 1'b0;
                    if (j_reg == DW'(DIM - 1))
                    begin
                        j_next = '0;
                        if (i_reg == DW'(DIM - 1))
                        begin
                            i_next = '0;
                            cnt_next = '0;
                            st_next = S_COPY;
                        end
                        else
                        begin
                            i_next = i_reg + DW'(1);
                            st_next = S_MULR;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + DW'(1);
                        st_next = S_MULR;
                    end
                end
            end
            S_COPY:
            begin
                st_next = S_COPW;
            end
            S_COPW:
            begin
                q_we = 1'b1;
                q_wd = p_rd;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next = '0;
                    if (k_reg == nt_reg)
                    begin
                        st_next = S_OUTR;
                    end
                    else
                    begin
                        k_next = k_reg + 8'd1;
                        st_next = S_SUMR;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                    st_next = S_COPY;
                end
            end
            S_OUTR:
            begin
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    res_next = s_rd;
                    last_next = (cnt_reg == AW'(CELLS - 1));
                    ov_out_next = ovf_reg;
                    if (cnt_reg == AW'(CELLS - 1))
                    begin
                        cnt_next = '0;
                        st_next = S_LOAD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + AW'(1);
                        st_next = S_OUTR;
                    end
                end
            end
            default:
            begin
                st_next = S_LOAD;
            end
        endcase

        // multiply sequencing: MULR issues reads, the RAMs register the data and prod_reg registers the product
        if (st_reg == S_MULA)
        begin
            if (!stuck_reg && m_reg != '0)
            begin
                if (asum > $signed({met_pkg::MAX64[63], met_pkg::MAX64}))
                begin
                    acc_next = met_pkg::MAX64; stuck_next = 1'b1; ovf_next = 1'b1;
                end
                else if (asum < $signed({met_pkg::MIN64[63], met_pkg::MIN64}))
                begin
                    acc_next = met_pkg::MIN64; stuck_next = 1'b1; ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = asum[63:0];
                end
            end
        end
    end

    // pipeline tracking for the multiply: pv1_reg and pv2_reg follow each MULR read into prod_reg
    logic       pv1_reg, pv2_reg;
    logic [1:0] tail_reg;
    logic signed [64:0] psum;
    logic signed [63:0] acc_fix;
    logic       stk_fix, ovf_fix;
    logic [3:0] st_fix;
    logic [DW-1:0] m_fix;

    always_comb
    begin
        acc_fix = acc_next;
        stk_fix = stuck_next;
        ovf_fix = ovf_next;
        st_fix = st_next;
        m_fix = m_next;
        psum = $signed({acc_reg[63], acc_reg}) + $signed({prod_reg[63], prod_reg});
        if (st_reg == S_MULR || st_reg == S_MULA)
        begin
            acc_fix = acc_reg;
            stk_fix = stuck_reg;
            ovf_fix = ovf_reg;
            if (pv2_reg && !stuck_reg)
            begin
                if (psum > $signed({met_pkg::MAX64[63], met_pkg::MAX64}))
                begin
                    acc_fix = met_pkg::MAX64; stk_fix = 1'b1; ovf_fix = 1'b1;
                end
                else if (psum < $signed({met_pkg::MIN64[63], met_pkg::MIN64}))
                begin
                    acc_fix = met_pkg::MIN64; stk_fix = 1'b1; ovf_fix = 1'b1;
                end
                else
                begin
                    acc_fix = psum[63:0];
                end
            end
            if (st_reg == S_MULR)
            begin
                st_fix = S_MULA;
            end
            else if (tail_reg == 2'd2)
            begin
                st_fix = S_DIV;
                m_fix = '0;
            end
            else if (tail_reg != 2'd0)
            begin
                st_fix = S_MULA;
            end
            else if (m_reg == DW'(DIM - 1))
            begin
                st_fix = S_MULA;
            end
            else
            begin
                m_fix = m_reg + DW'(1);
                st_fix = S_MULR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_LOAD;
            nt_reg <= 8'd100;
            cnt_reg <= '0;
            out_valid <= 1'b0;
            pv1_reg <= 1'b0;
            pv2_reg <= 1'b0;
            tail_reg <= 2'd0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_fix;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_fix;
            if (cfg_we)
            begin
                nt_reg <= cfg_data;
            end
            pv1_reg <= (st_reg == S_MULR);
            pv2_reg <= pv1_reg;
            if (st_reg == S_MULA && tail_reg == 2'd0 && m_reg == DW'(DIM - 1))
            begin
                tail_reg <= 2'd1;
            end
            else if (st_reg == S_MULA && tail_reg != 2'd0)
            begin
                tail_reg <= (tail_reg == 2'd2) ? 2'd0 : tail_reg + 2'd1;
            end
            if (st_reg == S_OUT && (!out_valid || !out_stall))
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        m_reg <= m_fix;
        k_reg <= k_next;
        stuck_reg <= stk_fix;
        acc_reg <= acc_fix;
        res_reg <= res_next;
        last_reg <= last_next;
        ov_out_reg <= ov_out_next;
    end

    assign result_value = res_reg;
    assign is_last = last_reg;
    assign saturated = ov_out_reg;

`ifndef SYNTH
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_LOAD) |-> in_stall)
        else $error("input taken while busy");
    a_div_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ddone |-> (st_reg == S_WAIT))
        else $error("divide result outside wait");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(result_value) && out_valid))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = 3;
    localparam int CELLS = N * N;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int TERMS_RESET = 100;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic               sat;
    } result_word_t;

    class expm_scoreboard;
        int unsigned        terms;
        logic signed [31:0] src [CELLS];
        int                 loaded;
        result_word_t       pending [$];
        int                 errors;
        int                 matrices;
        int                 results;
        int                 sat_seen;

        function new();
            terms = TERMS_RESET;
            loaded = 0;
            errors = 0;
            matrices = 0;
            results = 0;
            sat_seen = 0;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        function logic signed [31:0] clip32(longint v, inout bit ovf);
            if (v > longint'(met_pkg::MAX32)) begin
                ovf = 1;
                return met_pkg::MAX32;
            end
            if (v < longint'(met_pkg::MIN32)) begin
                ovf = 1;
                return met_pkg::MIN32;
            end
            return v[31:0];
        endfunction

        function logic signed [31:0] shrink(longint acc, int unsigned k1, inout bit ovf);
            longint unsigned d;
            longint unsigned mag;
            longint unsigned q;
            d = 64'd65536 * k1;
            mag = (acc < 0) ? (64'd0 - longint'(acc)) : acc;
            q = (mag + d / 2) / d;
            if (acc >= 0) begin
                if (q > 64'h7fffffff) begin
                    ovf = 1;
                    return met_pkg::MAX32;
                end
                return q[31:0];
            end
            if (q > 64'h80000000) begin
                ovf = 1;
                return met_pkg::MIN32;
            end
            return -longint'(q);
        endfunction

        function void expand();
            logic signed [31:0] s [CELLS];
            logic signed [31:0] q [CELLS];
            logic signed [31:0] p [CELLS];
            longint acc;
            longint prod;
            bit stuck;
            bit ovf;
            result_word_t w;
            ovf = 0;
            for (int i = 0; i < CELLS; i++)
            begin
                s[i] = (i / N == i % N) ? met_pkg::ONE_Q16 : 32'sd0;
                q[i] = src[i];
            end
            for (int unsigned k = 1; k <= terms; k++)
            begin
                for (int i = 0; i < CELLS; i++)
                    s[i] = clip32(longint'(s[i]) + longint'(q[i]), ovf);
                for (int i = 0; i < N; i++)
                    for (int j = 0; j < N; j++)
                    begin
                        acc = 0;
                        stuck = 0;
                        for (int m = 0; m < N; m++)
                        begin
                            prod = longint'(q[i * N + m]) * longint'(src[m * N + j]);
                            if (!stuck) begin
                                if (prod > 0 && acc > met_pkg::MAX64 - prod) begin
                                    stuck = 1;
                                    ovf = 1;
                                    acc = met_pkg::MAX64;
                                end else if (prod < 0 && acc < met_pkg::MIN64 - prod) begin
                                    stuck = 1;
                                    ovf = 1;
                                    acc = met_pkg::MIN64;
                                end else
                                    acc = acc + prod;
                            end
                        end
                        p[i * N + j] = shrink(acc, k + 1, ovf);
                    end
                q = p;
            end
            for (int i = 0; i < CELLS; i++)
            begin
                w.value = s[i];
                w.last = (i == CELLS - 1);
                w.sat = ovf;
                pending.push_back(w);
            end
            if (ovf)
                sat_seen++;
            matrices++;
        endfunction

        function void note_word(logic signed [31:0] v);
            src[loaded] = v;
            loaded++;
            if (loaded == CELLS) begin
                loaded = 0;
                expand();
            end
        endfunction

        task check_word(logic signed [31:0] v, logic last, logic sat);
            result_word_t w;
            results++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word %h", v));
                return;
            end
            w = pending.pop_front();
            if (v !== w.value)
                report($sformatf("value %h, want %h", v, w.value));
            if (last !== w.last)
                report($sformatf("is_last %b, want %b", last, w.last));
            if (sat !== w.sat)
                report($sformatf("saturated %b, want %b", sat, w.sat));
        endtask
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [31:0] elem_value = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [31:0] result_value;
    logic               is_last;
    logic               saturated;
    logic               cfg_we = 0;
    logic [7:0]         cfg_data = 0;

    expm_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;
    int idle_cycles = 0;

    matrix_exponential_taylor #(.DIM(N)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .elem_value(elem_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_value(result_value),
        .is_last(is_last),
        .saturated(saturated),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_word(result_value, is_last, saturated);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold on request once results appear
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && out_valid) begin
                hold_req = 0;
                out_stall <= 1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    task send_word(logic signed [31:0] v);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1;
        elem_value <= v;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        sb.note_word(v);
    endtask

    task set_terms(logic [7:0] v);
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.terms = v;
    endtask

    function logic signed [31:0] pick_elem();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            2: return 0;
            default: return $signed($urandom_range(0, 32'hffff)) - 32'sh8000;
        endcase
    endfunction

    task send_matrix(int kind);
        for (int i = 0; i < CELLS; i++)
        begin
            case (kind)
                1: send_word(met_pkg::MAX32);
                2: send_word(met_pkg::MIN32);
                3: send_word($signed($urandom_range(0, 32'h3fff)) - 32'sh2000);
                default: send_word(pick_elem());
            endcase
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // default term count straight after reset
        send_matrix(3);
        set_terms(0);
        send_matrix(0);
        set_terms(1);
        send_matrix(1);
        set_terms(3);
        send_matrix(2);
        set_terms(255);
        send_matrix(3);

        for (int n = 0; n < 6; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                set_terms(255);
            else
                set_terms($urandom_range(1, 12));
            if (n == 2)
                hold_req = 1;
            if (n >= 4)
                quiet = 1;
            send_matrix(0);
            if (n == 2)
                send_matrix(0);
        end
        in_valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (sb.loaded != 0)
            sb.report("partial matrix left in the predictor");
        $display("%0d matrices, %0d result words, %0d with saturation",
                 sb.matrices, sb.results, sb.sat_seen);
        $display("term counts from 0 to 255, including the reset value");
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
